// ===== hw/rtl/pcrms_pkg.sv =====
// Package with the widths, codes and state type of the per-channel RMS accumulator.
`default_nettype none

package pcrms_pkg;

	localparam int CHANNELS          = 64;
	localparam int MAX_SAMPLES_BOUND = 1024;
	localparam int SAMPLE_BITS       = 16;

	localparam int CH_W      = 6;
	localparam int CFG_MAX_W = 11;
	localparam int CFG_CH_W  = 7;
	localparam int SUM_W     = 41;
	localparam int CNT_W     = 11;
	localparam int SQ_W      = 2 * SAMPLE_BITS;
	localparam int RMS_W     = 16;
	localparam int ENTRY_W   = SUM_W + CNT_W;

	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = (SUM_W + 1) / 2;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_CH_W-1:0]  CHANNELS_C   = CFG_CH_W'(CHANNELS);
	localparam logic [CFG_MAX_W-1:0] MAX_BOUND_C  = CFG_MAX_W'(MAX_SAMPLES_BOUND);
	localparam logic [CNT_W-1:0]     COUNT_MAX_C  = '1;
	localparam logic [CFG_MAX_W-1:0] TAKEN_MAX_C  = '1;
	localparam logic [SUM_W-1:0]     SUM_MAX_C    = '1;
	localparam logic [RMS_W-1:0]     RMS_MAX_C    = '1;
	localparam logic [SUM_W-1:0]     SQRT_FIRST_C = SUM_W'(1) << (2 * (SQRT_STEPS - 1));

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_REQUEST = 2'd1,
		KIND_CLEAR   = 2'd2,
		KIND_NONE    = 2'd3
	} pcrms_kind_t;

	localparam logic CFG_MAX_SAMPLES = 1'b0;
	localparam logic CFG_CHANNELS    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_REQ,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} pcrms_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/per_channel_rms_accumulator_unit.sv =====
// Top level of the per-channel RMS accumulator: channel state memory, divider and root unit.
//
// Items enter on the s_axis channel. tuser holds the kind (add, request, clear), tlast marks
// the last channel value of a sample. For an add, the channel entry is read from the state
// memory at acceptance, the value is squared in the next cycle and the updated sum and count
// are written back in ST_ACCUM. The block takes one item at a time.
// A request reads each channel in use in turn and runs a bit-serial divider and a bit-serial
// square root on it when the channel holds present values; results leave on m_axis, one per
// channel, tlast on the final one. An empty interval gives a single result at once.
// The result sits in an output register, so the block takes the next item while the last
// result still waits; a stalled receiver holds a request's later channels in place.
// Reset clears the per-entry valid bits of the state memory, the sample count and the latch
// and returns the registers to 1024 samples and 64 channels; a clear item does the same to
// the interval. Registers must be written on cfg_we only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module per_channel_rms_accumulator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [pcrms_pkg::CFG_MAX_W-1:0]   cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: channel [5:0], value [21:6], value_present [22], zero fill [23]
	input  wire logic [pcrms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: kind
	input  wire logic [1:0]                        s_axis_tuser,
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// tdata: out_channel [5:0], rms [21:6], zero fill [23:22]
	output logic [pcrms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// tuser: rms_valid [0], interval_empty [1]
	output logic [1:0]                             m_axis_tuser,
	output logic                                   m_axis_tlast
);
	import pcrms_pkg::*;

	pcrms_state_t state_q, state_d;

	logic [CFG_MAX_W-1:0] max_samples_q;
	logic [CFG_CH_W-1:0]  channels_q;
	logic [CFG_MAX_W-1:0] taken_q;
	logic                 latched_q;
	logic [CHANNELS-1:0]  vld_q;

	logic [ENTRY_W-1:0] mem [CHANNELS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rd_vld_q;

	logic [CH_W-1:0]        add_ch_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [SQ_W-1:0]        sq_q;

	logic             empty_q;
	logic [CH_W-1:0]  idx_q;
	logic             res_valid_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] bit_q;
	logic [STEP_W-1:0] step_q;

	logic                  out_valid_q;
	logic [CH_W-1:0]       out_ch_q;
	logic [RMS_W-1:0]      out_rms_q;
	logic                  out_rvalid_q;
	logic                  out_empty_q;
	logic                  out_last_q;

	// Input field decode.
	logic [CH_W-1:0]        in_ch;
	logic [SAMPLE_BITS-1:0] in_raw;
	logic                   in_present;
	pcrms_kind_t            in_kind;
	logic                   in_accept;

	assign in_ch      = s_axis_tdata[CH_W-1:0];
	assign in_raw     = s_axis_tdata[CH_W+SAMPLE_BITS-1:CH_W];
	assign in_present = s_axis_tdata[CH_W+SAMPLE_BITS];
	assign in_kind    = pcrms_kind_t'(s_axis_tuser);
	assign in_accept  = s_axis_tvalid && s_axis_tready;

	// Effective register values.
	logic [CFG_CH_W-1:0]  eff_ch;
	logic [CFG_MAX_W-1:0] eff_max;

	always_comb begin
		if (channels_q == '0) begin
			eff_ch = CFG_CH_W'(1);
		end else if (channels_q > CHANNELS_C) begin
			eff_ch = CHANNELS_C;
		end else begin
			eff_ch = channels_q;
		end
		eff_max = (max_samples_q > MAX_BOUND_C) ? MAX_BOUND_C : max_samples_q;
	end

	logic add_ignore;
	logic add_use;
	assign add_ignore = latched_q || (taken_q >= eff_max);
	assign add_use    = in_present && ({1'b0, in_ch} < eff_ch);

	// Saturating update of the entry read at acceptance.
	logic [SUM_W-1:0] old_sum;
	logic [CNT_W-1:0] old_cnt;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] cnt_new;

	always_comb begin
		old_sum  = rd_vld_q ? rd_data_q[ENTRY_W-1:CNT_W] : '0;
		old_cnt  = rd_vld_q ? rd_data_q[CNT_W-1:0] : '0;
		sum_wide = {1'b0, old_sum} + (SUM_W + 1)'(sq_q);
		sum_new  = sum_wide[SUM_W] ? SUM_MAX_C : sum_wide[SUM_W-1:0];
		cnt_new  = (old_cnt == COUNT_MAX_C) ? old_cnt : old_cnt + CNT_W'(1);
	end

	// One restoring division step.
	logic [CNT_W:0]   div_trial;
	logic             div_ge;
	logic [CNT_W:0]   div_diff;
	logic [CNT_W-1:0] rem_next;
	logic [SUM_W-1:0] quo_next;

	always_comb begin
		div_trial = {rem_q, quo_q[SUM_W-1]};
		div_ge    = div_trial >= {1'b0, den_q};
		div_diff  = div_trial - {1'b0, den_q};
		rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
		quo_next  = {quo_q[SUM_W-2:0], div_ge};
	end

	// One square root step: two bits of the radicand per cycle.
	logic [SUM_W:0] sqrt_trial;
	logic           sqrt_ge;
	logic [SUM_W:0] sqrt_diff;

	always_comb begin
		sqrt_trial = {1'b0, root_q} + {1'b0, bit_q};
		sqrt_ge    = {1'b0, quo_q} >= sqrt_trial;
		sqrt_diff  = {1'b0, quo_q} - sqrt_trial;
	end

	logic            out_free;
	logic            emit_last;
	logic [RMS_W-1:0] rms_sat;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign emit_last = empty_q || (({1'b0, idx_q} + CFG_CH_W'(1)) == eff_ch);
	assign rms_sat   = (root_q > SUM_W'(RMS_MAX_C)) ? RMS_MAX_C : root_q[RMS_W-1:0];

	// Control outputs.
	logic            mem_re;
	logic            mem_we;
	logic            out_load;
	logic [CH_W-1:0] rd_addr;

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		mem_re        = (state_q == ST_READ) || ((state_q == ST_IDLE) && in_accept);
		mem_we        = (state_q == ST_ACCUM);
		out_load      = (state_q == ST_EMIT) && out_free;
		rd_addr       = (state_q == ST_READ) ? idx_q : in_ch;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (in_kind)
						KIND_ADD: begin
							if (!add_ignore && add_use) state_d = ST_SQUARE;
						end
						KIND_REQUEST: state_d = ST_REQ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SQUARE: state_d = ST_ACCUM;
			ST_ACCUM:  state_d = ST_IDLE;
			ST_REQ:    state_d = (taken_q == '0) ? ST_EMIT : ST_READ;
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD: begin
				if (rd_vld_q && (rd_data_q[CNT_W-1:0] != '0)) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (step_q == '0) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_q == '0) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = emit_last ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_samples_q <= MAX_BOUND_C;
			channels_q    <= CHANNELS_C;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_SAMPLES: max_samples_q <= cfg_data;
				CFG_CHANNELS:    channels_q    <= cfg_data[CFG_CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Interval control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q   <= '0;
			latched_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			if ((state_q == ST_IDLE) && in_accept) begin
				case (in_kind)
					KIND_ADD: begin
						if (!add_ignore && s_axis_tlast && (taken_q != TAKEN_MAX_C)) begin
							taken_q <= taken_q + CFG_MAX_W'(1);
						end
					end
					KIND_CLEAR: begin
						taken_q   <= '0;
						latched_q <= 1'b0;
						vld_q     <= '0;
					end
					default: ;
				endcase
			end
			if ((state_q == ST_REQ) && (taken_q != '0)) latched_q <= 1'b1;
			if (mem_we) vld_q[add_ch_q] <= 1'b1;
		end
	end

	// Channel state memory: sum of squares over present count.
	always_ff @(posedge clk) begin
		if (mem_we) mem[add_ch_q] <= {sum_new, cnt_new};
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	// Add path and request datapath.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_accept) begin
			add_ch_q <= in_ch;
			// The two's complement of the most negative value reads as its magnitude.
			mag_q    <= in_raw[SAMPLE_BITS-1] ? (~in_raw + SAMPLE_BITS'(1)) : in_raw;
		end
		if (state_q == ST_SQUARE) sq_q <= SQ_W'(mag_q) * SQ_W'(mag_q);

		case (state_q)
			ST_REQ: begin
				empty_q <= (taken_q == '0);
				idx_q   <= '0;
			end
			ST_LOAD: begin
				res_valid_q <= rd_vld_q && (rd_data_q[CNT_W-1:0] != '0);
				quo_q       <= rd_data_q[ENTRY_W-1:CNT_W];
				den_q       <= rd_data_q[CNT_W-1:0];
				rem_q       <= '0;
				root_q      <= '0;
				step_q      <= STEP_W'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= rem_next;
				if (step_q == '0) begin
					root_q <= '0;
					bit_q  <= SQRT_FIRST_C;
					step_q <= STEP_W'(SQRT_STEPS - 1);
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
			ST_SQRT: begin
				if (sqrt_ge) begin
					quo_q  <= sqrt_diff[SUM_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q - STEP_W'(1);
			end
			ST_EMIT: begin
				if (out_free && !emit_last) idx_q <= idx_q + CH_W'(1);
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q     <= empty_q ? '0 : idx_q;
			out_rms_q    <= (empty_q || !res_valid_q) ? '0 : rms_sat;
			out_rvalid_q <= !empty_q && res_valid_q;
			out_empty_q  <= empty_q;
			out_last_q   <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - CH_W - RMS_W)'(0), out_rms_q, out_ch_q};
	assign m_axis_tuser  = {out_empty_q, out_rvalid_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/per_channel_rms_accumulator_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the per-channel RMS accumulator: stimulus, predictor and result check.
module per_channel_rms_accumulator_unit_test;
	import pcrms_pkg::*;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS  = 40;
	localparam int MAX_REPORTS   = 10;
	localparam int STALL_CYCLES  = 400;

	typedef struct {
		logic [CH_W-1:0]  chan;
		logic [RMS_W-1:0] rms;
		logic             rms_ok;
		logic             is_empty;
		logic             is_last;
	} rms_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_MAX_W-1:0]  cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	// Predicted interval state and register copies.
	logic [SUM_W-1:0]     sum_of_squares [CHANNELS];
	logic [CNT_W-1:0]     present_values [CHANNELS];
	logic [CFG_MAX_W-1:0] samples_done;
	logic                 interval_latched;
	logic [CFG_MAX_W-1:0] limit_samples;
	logic [CFG_CH_W-1:0]  channel_limit;

	rms_result_t expected_results[$];

	int unsigned cycle_count     = 0;
	int unsigned items_sent      = 0;
	int unsigned requests_sent   = 0;
	int unsigned config_writes   = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count  = 0;
	int unsigned sink_hold       = 0;
	bit          steady_flow     = 1'b0;

	per_channel_rms_accumulator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("FAIL per_channel_rms_accumulator_unit");
			$finish;
		end
	end

	function automatic int unsigned active_channels();
		if (channel_limit == 0)
			return 1;
		return (channel_limit > CHANNELS) ? CHANNELS : channel_limit;
	endfunction

	function automatic int unsigned sample_limit();
		return (limit_samples > MAX_SAMPLES_BOUND) ? MAX_SAMPLES_BOUND : limit_samples;
	endfunction

	function automatic void clear_sums();
		for (int i = 0; i < CHANNELS; i++) begin
			sum_of_squares[i] = '0;
			present_values[i] = '0;
		end
		samples_done = '0;
		interval_latched = 1'b0;
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] x);
		logic [63:0] r, trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= x)
				r = trial;
		end
		return r;
	endfunction

	function automatic void accumulate_value(logic [CH_W-1:0] ch, logic [SAMPLE_BITS-1:0] value,
			bit present, bit eos);
		logic [SAMPLE_BITS-1:0]   magnitude;
		logic [2*SAMPLE_BITS-1:0] square;
		logic [SUM_W:0]           total;
		if (interval_latched || samples_done >= sample_limit())
			return;
		if (present && ch < active_channels()) begin
			// The 16-bit negation of the most negative value wraps to 32768, which is right.
			magnitude = value[SAMPLE_BITS-1] ? -value : value;
			square = (2*SAMPLE_BITS)'(magnitude) * (2*SAMPLE_BITS)'(magnitude);
			total = {1'b0, sum_of_squares[ch]} + (SUM_W + 1)'(square);
			sum_of_squares[ch] = (total > {1'b0, SUM_MAX_C}) ? SUM_MAX_C : total[SUM_W-1:0];
			if (present_values[ch] != COUNT_MAX_C)
				present_values[ch]++;
		end
		if (eos && samples_done != TAKEN_MAX_C)
			samples_done++;
	endfunction

	function automatic void request_results();
		rms_result_t row;
		int unsigned n;
		logic [SUM_W-1:0] mean;
		logic [63:0] root;
		if (samples_done == 0) begin
			row.chan = '0;
			row.rms = '0;
			row.rms_ok = 1'b0;
			row.is_empty = 1'b1;
			row.is_last = 1'b1;
			expected_results.insert(expected_results.size(), row);
			return;
		end
		interval_latched = 1'b1;
		n = active_channels();
		for (int i = 0; i < n; i++) begin
			row.chan = CH_W'(i);
			row.is_empty = 1'b0;
			row.is_last = (i == n - 1);
			if (present_values[i] != 0) begin
				mean = sum_of_squares[i] / present_values[i];
				root = floor_root(64'(mean));
				row.rms = (root > 64'd65535) ? RMS_MAX_C : root[RMS_W-1:0];
				row.rms_ok = 1'b1;
			end else begin
				row.rms = '0;
				row.rms_ok = 1'b0;
			end
			expected_results.insert(expected_results.size(), row);
		end
	endfunction

	function automatic void apply_item(pcrms_kind_t kind, logic [CH_W-1:0] ch,
			logic [SAMPLE_BITS-1:0] value, bit present, bit eos);
		case (kind)
			KIND_ADD: accumulate_value(ch, value, present, eos);
			KIND_REQUEST: begin
				requests_sent++;
				request_results();
			end
			KIND_CLEAR: clear_sums();
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what, rms_result_t want, rms_result_t seen);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("Mismatch (%s): expected ch %0d rms %0d valid %0b empty %0b last %0b",
				what, want.chan, want.rms, want.rms_ok, want.is_empty, want.is_last,
				"; got ch %0d rms %0d valid %0b empty %0b last %0b",
				seen.chan, seen.rms, seen.rms_ok, seen.is_empty, seen.is_last);
	endfunction

	task automatic check_result();
		rms_result_t want, seen;
		string fields;
		seen.chan = m_axis_tdata[CH_W-1:0];
		seen.rms = m_axis_tdata[CH_W +: RMS_W];
		seen.rms_ok = m_axis_tuser[0];
		seen.is_empty = m_axis_tuser[1];
		seen.is_last = m_axis_tlast;
		results_checked++;
		if (expected_results.size() == 0) begin
			want = '{default: '0};
			note_mismatch("result with nothing expected", want, seen);
		end else begin
			want = expected_results.pop_front();
			fields = "";
			if (seen.chan !== want.chan)
				fields = {fields, " out_channel"};
			if (seen.rms !== want.rms)
				fields = {fields, " rms"};
			if (seen.rms_ok !== want.rms_ok)
				fields = {fields, " rms_valid"};
			if (seen.is_empty !== want.is_empty)
				fields = {fields, " interval_empty"};
			if (seen.is_last !== want.is_last)
				fields = {fields, " last"};
			if (fields != "")
				note_mismatch({"wrong", fields}, want, seen);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
	end

	// Result receiver: a random stall before each result, or a long one when a test asks.
	initial begin : result_sink
		int unsigned gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold != 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end else begin
				gap = steady_flow ? 0 : $urandom_range(0, 5);
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Valid stays high into the next item when no gap is drawn.
	task automatic send_item(pcrms_kind_t kind, logic [CH_W-1:0] ch,
			logic [SAMPLE_BITS-1:0] value, bit present, bit eos);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {1'b0, present, value, ch};
		s_axis_tlast <= eos;
		do @(posedge clk); while (!s_axis_tready);
		apply_item(kind, ch, value, present, eos);
		items_sent++;
		gap = steady_flow ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic release_input();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
	endtask

	// Adds and clears give no result, so the block may still be busy once the queue drains.
	task automatic wait_idle();
		release_input();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int unsigned sample_cap, int unsigned chan_count);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_SAMPLES;
		cfg_data <= CFG_MAX_W'(sample_cap);
		@(posedge clk);
		limit_samples = CFG_MAX_W'(sample_cap);
		cfg_index <= CFG_CHANNELS;
		cfg_data <= CFG_MAX_W'(chan_count);
		@(posedge clk);
		channel_limit = CFG_CH_W'(chan_count);
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_random(pcrms_kind_t kind);
		send_item(kind, CH_W'($urandom), random_value(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 2) == 0)
			send_random(KIND_NONE);
		else
			send_random(KIND_ADD);
	endtask

	task automatic test_empty_and_latch();
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_NONE, 6'd63, 16'hFFFF, 1'b1, 1'b1);
		// A value without an end mark leaves the interval empty, but joins it later.
		send_item(KIND_ADD, 6'd0, 16'h7FFF, 1'b1, 1'b0);
		send_item(KIND_REQUEST, 6'd63, 16'hFFFF, 1'b1, 1'b1);
		send_item(KIND_ADD, 6'd63, 16'h8000, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_ADD, 6'd5, 16'd100, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
	endtask

	task automatic test_value_extremes();
		send_item(KIND_ADD, 6'd1, 16'd1234, 1'b0, 1'b1);
		send_item(KIND_ADD, 6'd2, 16'hFFFF, 1'b1, 1'b0);
		send_item(KIND_ADD, 6'd2, 16'h0000, 1'b1, 1'b0);
		send_item(KIND_ADD, 6'd2, 16'h0001, 1'b1, 1'b1);
		send_item(KIND_ADD, 6'd62, 16'h8000, 1'b1, 1'b0);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
	endtask

	task automatic test_register_limits();
		// No sample fits; channel count zero behaves as one.
		set_config(0, 0);
		send_item(KIND_ADD, 6'd0, 16'd5, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		set_config(1, 1);
		send_item(KIND_ADD, 6'd0, 16'd3, 1'b1, 1'b0);
		send_item(KIND_ADD, 6'd0, 16'd4, 1'b1, 1'b1);
		send_item(KIND_ADD, 6'd0, 16'd100, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		// A channel beyond the ones in use still closes its sample.
		set_config(11'h7FF, 2);
		send_item(KIND_ADD, 6'd5, 16'd77, 1'b1, 1'b1);
		send_item(KIND_ADD, 6'd1, -16'sd300, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		set_config(MAX_SAMPLES_BOUND, 11'h7FF);
		send_item(KIND_ADD, 6'd40, 16'd1000, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
	endtask

	// Back-to-back full-scale values on one channel give the largest squares.
	task automatic test_full_scale();
		set_config(MAX_SAMPLES_BOUND, 1);
		steady_flow = 1'b1;
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		repeat (4) send_item(KIND_ADD, 6'd0, 16'h8000, 1'b1, 1'b0);
		send_item(KIND_ADD, 6'd0, 16'h8000, 1'b1, 1'b1);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		steady_flow = 1'b0;
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
	endtask

	task automatic test_output_stall();
		set_config(MAX_SAMPLES_BOUND, 64);
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		repeat (2) begin
			for (int ch = 0; ch < 8; ch++)
				send_item(KIND_ADD, CH_W'(ch), random_value(), 1'b1, ch == 7);
		end
		sink_hold = STALL_CYCLES;
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
		// These wait at the input while the receiver holds the request's results back.
		send_item(KIND_CLEAR, 6'd0, 16'h0000, 1'b0, 1'b0);
		for (int ch = 0; ch < 4; ch++)
			send_item(KIND_ADD, CH_W'(ch * 16 + 3), random_value(), 1'b1, ch == 3);
		send_item(KIND_REQUEST, 6'd0, 16'h0000, 1'b0, 1'b0);
	endtask

	task automatic test_random_intervals();
		int unsigned first_item, n_ch, n_samples, sample_cap;
		bit eos;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			n_ch = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
			case ($urandom_range(0, 3))
				0: sample_cap = MAX_SAMPLES_BOUND;
				1: sample_cap = 11'h7FF;
				default: sample_cap = $urandom_range(1, 3);
			endcase
			set_config(sample_cap, n_ch);
			steady_flow = ($urandom_range(0, 3) == 0);
			send_random(KIND_CLEAR);
			n_samples = $urandom_range(1, 4);
			repeat (n_samples) begin
				for (int ch = 0; ch < n_ch; ch++) begin
					if ($urandom_range(0, 9) == 0)
						send_noise();
					// Now and then the end mark is dropped, merging two samples.
					eos = (ch == n_ch - 1) && ($urandom_range(0, 11) != 0);
					send_item(KIND_ADD, CH_W'(ch), random_value(),
						$urandom_range(0, 7) != 0, eos);
				end
			end
			send_random(KIND_REQUEST);
			if ($urandom_range(0, 2) == 0) begin
				send_noise();
				send_random(KIND_REQUEST);
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MAX_SAMPLES;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_ADD;
		s_axis_tlast <= 1'b0;
		limit_samples = MAX_BOUND_C;
		channel_limit = CHANNELS_C;
		clear_sums();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_latch();
		test_value_extremes();
		test_register_limits();
		test_full_scale();
		test_output_stall();
		test_random_intervals();

		release_input();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("Run sent %0d items with %0d requests over %0d register settings.",
			items_sent, requests_sent, config_writes);
		$display("Checked %0d results, %0d of them wrong.", results_checked, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASS per_channel_rms_accumulator_unit");
		else
			$display("FAIL per_channel_rms_accumulator_unit");
		$finish;
	end

endmodule

// ===== per_channel_rms_accumulator_unit.f =====
hw/rtl/pcrms_pkg.sv
hw/rtl/per_channel_rms_accumulator_unit.sv
tb/per_channel_rms_accumulator_unit_test.sv
